[hw/rtl/sbxc_pkg.sv]
package sbxc_pkg;

  // Fraction bits of the internal log2/exp2 format.
  localparam int Q_FRAC = 30;
  // Signed width of a log2 result, integer part from -62 to 63.
  localparam int LOG_W = 38;
  // Signed width of an exp2 argument.
  localparam int EXP_W = 46;
  // Divider: a scaled log magnitude over the distribution index plus one.
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 16;

  typedef logic [31:0] root_tab_t [0:30];

  function automatic logic [63:0] sbxc_isqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] rem;
    r = '0;
    bit_v = 64'h4000_0000_0000_0000;
    rem = n;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^(2^-k) in Q.30, each one the truncated square root of the last.
  function automatic root_tab_t sbxc_make_roots();
    root_tab_t t;
    t[0] = 32'h8000_0000;
    for (int k = 1; k <= 30; k++) begin
      t[k] = 32'(sbxc_isqrt({32'b0, t[k-1]} << 30));
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = sbxc_make_roots();

endpackage

[hw/rtl/sbxc_div.sv]
module sbxc_div
  import sbxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] q_r, q_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle, numerator shifted out as
  // quotient bits shift in.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    trial    = {rem_r, q_r[DIV_NW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      q_nxt   = {q_r[DIV_NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[hw/rtl/simulated_binary_crossover_core.sv]
// Simulated binary crossover for one decision variable per input word. A word with
// the first-variable flag set starts a parent pair and decides from its draw and the
// crossover rate whether the pair is crossed; later words of the pair reuse that
// decision. A crossed, blended variable whose parents differ yields two children
// spread by the bounded SBX rule and clamped to the bounds; other variables come out
// swapped or copied. A copied or swapped variable goes from the prepare state straight
// to the done state; a blended one is paced by the single shared multiplier that steps
// each log2 squaring and each exp2 root product one bit per cycle (up to nine power
// evaluations) and by the divider, run up to twice. The block accepts one word at a
// time; a finished result waits in the output register while the next word is taken.
module simulated_binary_crossover_core
  import sbxc_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0: pair_draw, parent_a, parent_b, lower_bound, upper_bound,
  // blend_coin, spread_draw, order_coin, then zero fill.
  input  logic [((16 + 4 * VALUE_WIDTH + 34 + 7) / 8) * 8 - 1:0] in_tdata,
  // Fields from bit 0: first_var.
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0: child_one, child_two, then zero fill.
  output logic [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int VW     = VALUE_WIDTH;
  localparam int OUT_W  = ((2 * VW + 7) / 8) * 8;
  localparam int OFF_A  = 16;
  localparam int OFF_B  = 16 + VW;
  localparam int OFF_LO = 16 + 2 * VW;
  localparam int OFF_HI = 16 + 3 * VW;
  localparam int OFF_BC = 16 + 4 * VW;
  localparam int OFF_U  = OFF_BC + 1;
  localparam int OFF_OC = OFF_U + 32;
  localparam int MOP    = (VW > 36) ? VW : 36;
  localparam int PW     = 2 * MOP;
  localparam int CW     = ((VW + 3 > 47) ? VW + 3 : 47) + 2;
  localparam int NUMW   = VW + 2;
  localparam logic [63:0] EPS_LSB = (64'd10 << FRACTION_BITS) / 64'd1000000;

  localparam logic REG_RATE = 1'b0;
  localparam logic REG_ETA  = 1'b1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_NORM = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_EXPM = 4'd4;
  localparam logic [3:0] ST_EXPF = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_NEXT = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam logic [3:0] STEP_LOGD = 4'd0;
  localparam logic [3:0] STEP_LOGN = 4'd1;
  localparam logic [3:0] STEP_T    = 4'd2;
  localparam logic [3:0] STEP_EXPP = 4'd3;
  localparam logic [3:0] STEP_PROD = 4'd4;
  localparam logic [3:0] STEP_LOGG = 4'd5;
  localparam logic [3:0] STEP_DIV  = 4'd6;
  localparam logic [3:0] STEP_EXPB = 4'd7;
  localparam logic [3:0] STEP_BH   = 4'd8;
  localparam logic [3:0] STEP_BL   = 4'd9;

  localparam logic [PW-1:0] SAT_P = PW'(1) << 45;
  localparam logic [46:0]   SAT_W = 47'(1) << 45;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        side_r, side_nxt;
  logic        pc_r, pc_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic [14:0] eta_r, eta_nxt;
  logic        ov_r, ov_nxt;

  logic signed [VW-1:0] a_r, a_nxt, b_r, b_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0]          u_r, u_nxt;
  logic                 blend_r, blend_nxt, order_r, order_nxt;
  logic signed [VW-1:0] y1_r, y1_nxt, y2_r, y2_nxt;
  logic [VW-1:0]        d_r, d_nxt;
  logic signed [VW:0]   s_r, s_nxt;
  logic [63:0]          x_r, x_nxt;
  logic [5:0]           lz_r, lz_nxt;
  logic                 fb_r, fb_nxt;
  logic [31:0]          m_r, m_nxt;
  logic [29:0]          frac_r, frac_nxt;
  logic signed [LOG_W-1:0] lg_r, lg_nxt, lgd_r, lgd_nxt;
  logic [35:0]          lb_r, lb_nxt;
  logic signed [EXP_W-1:0] y_r, y_nxt;
  logic [63:0]          ex_r, ex_nxt;
  logic [31:0]          alpha_r, alpha_nxt;
  logic                 hiside_r, hiside_nxt;
  logic [PW-1:0]        mres_r, mres_nxt;
  logic [63:0]          bq_r, bq_nxt;
  logic                 sat_r, sat_nxt;
  logic [45:0]          bhd_r, bhd_nxt;
  logic signed [VW-1:0] clo_r, clo_nxt;
  logic [VW-1:0]        res1_r, res1_nxt, res2_r, res2_nxt;
  logic [VW-1:0]        out1_r, out1_nxt, out2_r, out2_nxt;

  logic                 in_acc;
  logic [15:0]          e_val;
  logic [MOP-1:0]       mul_a, mul_b;
  logic [PW-1:0]        mul_p;

  logic [5:0]           sh;
  logic [63:0]          top_mask;
  logic                 top_nz;
  logic [63:0]          x_sh;
  logic [5:0]           lz_sh;
  logic [31:0]          sq;
  logic [7:0]           pfb;
  logic [31:0]          em;
  logic [4:0]           fidx;
  logic [29:0]          yfrac;
  logic signed [15:0]   ip;
  logic [4:0]           nip;
  logic [63:0]          ex_val;

  logic signed [VW:0]   a_x, b_x, diff_ab, abs_ab;
  logic                 a_lt;
  logic signed [VW:0]   gap_lo, gap_up;
  logic [VW-1:0]        gpos_lo, gpos_up;
  logic [NUMW-1:0]      num_lo, num_up;
  logic signed [LOG_W-1:0] lbs, lgneg;
  logic [43:0]          t_val;
  logic [31:0]          p_cl;
  logic [63:0]          prod;
  logic [35:0]          g_val;
  logic                 div_start, div_done;
  logic [DIV_NW-1:0]    div_q;

  logic [VW-1:0]        bld;
  logic [46:0]          w_sum, w_val;
  logic signed [CW-1:0] s4, w_ext, csum, c_fl, lo_ext, hi_ext, c_a, c_b;
  logic signed [VW-1:0] child;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign e_val     = {1'b0, eta_r} + 16'd256;

  // The one shared multiplier; its operands follow the current state and step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = MOP'(m_r);
        mul_b = MOP'(m_r);
      end
      ST_EXPM: begin
        mul_a = MOP'(m_r);
        mul_b = MOP'(ROOTS[cnt_r]);
      end
      ST_MUL: begin
        unique case (step_r)
          STEP_T: begin
            mul_a = MOP'(lb_r);
            mul_b = MOP'(e_val);
          end
          STEP_PROD: begin
            mul_a = MOP'(u_r);
            mul_b = MOP'(alpha_r);
          end
          STEP_BH: begin
            mul_a = MOP'(bq_r[63:28]);
            mul_b = MOP'(d_r);
          end
          STEP_BL: begin
            mul_a = MOP'(bq_r[27:0]);
            mul_b = MOP'(d_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Leading-zero search by halving shifts, then log2 fraction by squaring.
  assign sh       = 6'd32 >> cnt_r;
  assign top_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> sh);
  assign top_nz   = |(x_r & top_mask);
  assign x_sh     = top_nz ? x_r : (x_r << sh);
  assign lz_sh    = top_nz ? lz_r : (lz_r + sh);
  assign sq       = mul_p[61:30];
  assign pfb      = 8'd63 - {2'b00, lz_r} - (fb_r ? 8'd62 : 8'd0);

  // exp2 as a product of root factors, then scaling by the integer part.
  assign em    = mul_p[61:30];
  assign fidx  = 5'd30 - cnt_r;
  assign yfrac = y_r[29:0];
  assign ip    = y_r[EXP_W-1:30];
  assign nip   = 5'(-ip);

  always_comb begin
    if (ip > 16'sd32) begin
      ex_val = '1;
    end else if (ip >= 16'sd0) begin
      ex_val = {32'b0, m_r} << ip[5:0];
    end else if (ip <= -16'sd32) begin
      ex_val = '0;
    end else begin
      ex_val = {32'b0, m_r} >> nip;
    end
  end

  assign a_x     = {a_r[VW-1], a_r};
  assign b_x     = {b_r[VW-1], b_r};
  assign diff_ab = a_x - b_x;
  assign abs_ab  = diff_ab[VW] ? -diff_ab : diff_ab;
  assign a_lt    = a_r < b_r;

  // A parent outside its bounds gives a negative gap, which counts as zero.
  assign gap_lo  = $signed({y1_r[VW-1], y1_r}) - $signed({lo_r[VW-1], lo_r});
  assign gap_up  = $signed({hi_r[VW-1], hi_r}) - $signed({y2_r[VW-1], y2_r});
  assign gpos_lo = gap_lo[VW] ? '0 : gap_lo[VW-1:0];
  assign gpos_up = gap_up[VW] ? '0 : gap_up[VW-1:0];
  assign num_lo  = {2'b00, d_r} + {1'b0, gpos_lo, 1'b0};
  assign num_up  = {2'b00, d_r} + {1'b0, gpos_up, 1'b0};

  assign lbs   = lg_r - lgd_r;
  assign lgneg = -lg_r;
  assign t_val = mres_r[51:8];
  assign p_cl  = (ex_r > 64'h4000_0000) ? 32'h4000_0000 : ex_r[31:0];
  assign prod  = mres_r[63:0];
  assign g_val = div_q[35:0];

  // Child from the spread, kept to a quarter LSB, rounded half up and clamped.
  assign bld    = mres_r[28 +: VW];
  assign w_sum  = {1'b0, bhd_r} + 47'(bld);
  assign w_val  = (sat_r || (w_sum > SAT_W)) ? SAT_W : w_sum;
  assign s4     = $signed({{(CW - VW - 1){s_r[VW]}}, s_r}) <<< 2;
  assign w_ext  = $signed({{(CW - 47){1'b0}}, w_val});
  assign csum   = side_r ? (s4 + w_ext + CW'(4)) : (s4 - w_ext + CW'(4));
  assign c_fl   = csum >>> 3;
  assign lo_ext = $signed({{(CW - VW){lo_r[VW-1]}}, lo_r});
  assign hi_ext = $signed({{(CW - VW){hi_r[VW-1]}}, hi_r});
  assign c_a    = (c_fl < lo_ext) ? lo_ext : c_fl;
  assign c_b    = (c_a > hi_ext) ? hi_ext : c_a;
  assign child  = c_b[VW-1:0];

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    side_nxt   = side_r;
    pc_nxt     = pc_r;
    rate_nxt   = rate_r;
    eta_nxt    = eta_r;
    ov_nxt     = ov_r && !out_tready;
    a_nxt      = a_r;
    b_nxt      = b_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    u_nxt      = u_r;
    blend_nxt  = blend_r;
    order_nxt  = order_r;
    y1_nxt     = y1_r;
    y2_nxt     = y2_r;
    d_nxt      = d_r;
    s_nxt      = s_r;
    x_nxt      = x_r;
    lz_nxt     = lz_r;
    fb_nxt     = fb_r;
    m_nxt      = m_r;
    frac_nxt   = frac_r;
    lg_nxt     = lg_r;
    lgd_nxt    = lgd_r;
    lb_nxt     = lb_r;
    y_nxt      = y_r;
    ex_nxt     = ex_r;
    alpha_nxt  = alpha_r;
    hiside_nxt = hiside_r;
    mres_nxt   = mres_r;
    bq_nxt     = bq_r;
    sat_nxt    = sat_r;
    bhd_nxt    = bhd_r;
    clo_nxt    = clo_r;
    res1_nxt   = res1_r;
    res2_nxt   = res2_r;
    out1_nxt   = out1_r;
    out2_nxt   = out2_r;
    div_start  = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE: rate_nxt = cfg_wdata;
        REG_ETA:  eta_nxt  = cfg_wdata[14:0];
        default:  rate_nxt = rate_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            pc_nxt = in_tdata[15:0] < rate_r;
          end
          a_nxt     = in_tdata[OFF_A +: VW];
          b_nxt     = in_tdata[OFF_B +: VW];
          lo_nxt    = in_tdata[OFF_LO +: VW];
          hi_nxt    = in_tdata[OFF_HI +: VW];
          blend_nxt = in_tdata[OFF_BC];
          u_nxt     = in_tdata[OFF_U +: 32];
          order_nxt = in_tdata[OFF_OC];
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        res1_nxt = a_r;
        res2_nxt = b_r;
        if (!pc_r) begin
          state_nxt = ST_DONE;
        end else if (!blend_r) begin
          res1_nxt  = b_r;
          res2_nxt  = a_r;
          state_nxt = ST_DONE;
        end else if (64'(abs_ab) <= EPS_LSB) begin
          state_nxt = ST_DONE;
        end else begin
          y1_nxt    = a_lt ? a_r : b_r;
          y2_nxt    = a_lt ? b_r : a_r;
          d_nxt     = a_lt ? VW'(b_x - a_x) : VW'(a_x - b_x);
          s_nxt     = a_x + b_x;
          side_nxt  = 1'b0;
          x_nxt     = 64'($unsigned(a_lt ? VW'(b_x - a_x) : VW'(a_x - b_x)));
          fb_nxt    = 1'b0;
          lz_nxt    = '0;
          cnt_nxt   = '0;
          step_nxt  = STEP_LOGD;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        x_nxt  = x_sh;
        lz_nxt = lz_sh;
        if (cnt_r == 5'd5) begin
          m_nxt     = {1'b0, x_sh[63:33]};
          frac_nxt  = '0;
          cnt_nxt   = 5'd29;
          state_nxt = ST_SQ;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SQ: begin
        if (sq[31]) begin
          m_nxt = {1'b0, sq[31:1]};
          frac_nxt[cnt_r] = 1'b1;
        end else begin
          m_nxt = sq;
        end
        if (cnt_r == 5'd0) begin
          lg_nxt    = $signed({pfb, frac_nxt});
          state_nxt = ST_NEXT;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_EXPM: begin
        if (yfrac[fidx]) begin
          m_nxt = em;
        end
        if (cnt_r == 5'd30) begin
          state_nxt = ST_EXPF;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_EXPF: begin
        ex_nxt    = ex_val;
        state_nxt = ST_NEXT;
      end
      ST_MUL: begin
        mres_nxt  = mul_p;
        state_nxt = ST_NEXT;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        unique case (step_r)
          STEP_LOGD: begin
            lgd_nxt   = lg_r;
            x_nxt     = 64'(num_lo);
            fb_nxt    = 1'b0;
            lz_nxt    = '0;
            cnt_nxt   = '0;
            step_nxt  = STEP_LOGN;
            state_nxt = ST_NORM;
          end
          STEP_LOGN: begin
            lb_nxt    = lbs[LOG_W-1] ? '0 : lbs[35:0];
            step_nxt  = STEP_T;
            state_nxt = ST_MUL;
          end
          STEP_T: begin
            y_nxt     = -$signed({2'b00, t_val});
            m_nxt     = 32'h4000_0000;
            cnt_nxt   = 5'd1;
            step_nxt  = STEP_EXPP;
            state_nxt = ST_EXPM;
          end
          STEP_EXPP: begin
            alpha_nxt = 32'h8000_0000 - p_cl;
            step_nxt  = STEP_PROD;
            state_nxt = ST_MUL;
          end
          STEP_PROD: begin
            if (prod == 64'd0) begin
              bq_nxt    = '0;
              step_nxt  = STEP_BH;
              state_nxt = ST_MUL;
            end else begin
              hiside_nxt = prod > 64'h4000_0000_0000_0000;
              x_nxt      = (prod > 64'h4000_0000_0000_0000) ?
                           (64'h8000_0000_0000_0000 - prod) : prod;
              fb_nxt     = 1'b1;
              lz_nxt     = '0;
              cnt_nxt    = '0;
              step_nxt   = STEP_LOGG;
              state_nxt  = ST_NORM;
            end
          end
          STEP_LOGG: begin
            div_start = 1'b1;
            step_nxt  = STEP_DIV;
            state_nxt = ST_DIV;
          end
          STEP_DIV: begin
            y_nxt     = hiside_r ? $signed({10'b0, g_val}) : -$signed({10'b0, g_val});
            m_nxt     = 32'h4000_0000;
            cnt_nxt   = 5'd1;
            step_nxt  = STEP_EXPB;
            state_nxt = ST_EXPM;
          end
          STEP_EXPB: begin
            bq_nxt    = ex_r;
            step_nxt  = STEP_BH;
            state_nxt = ST_MUL;
          end
          STEP_BH: begin
            sat_nxt   = mres_r > SAT_P;
            bhd_nxt   = mres_r[45:0];
            step_nxt  = STEP_BL;
            state_nxt = ST_MUL;
          end
          STEP_BL: begin
            if (!side_r) begin
              clo_nxt   = child;
              side_nxt  = 1'b1;
              x_nxt     = 64'(num_up);
              fb_nxt    = 1'b0;
              lz_nxt    = '0;
              cnt_nxt   = '0;
              step_nxt  = STEP_LOGN;
              state_nxt = ST_NORM;
            end else begin
              res1_nxt  = order_r ? child : clo_r;
              res2_nxt  = order_r ? clo_r : child;
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          out1_nxt  = res1_r;
          out2_nxt  = res2_r;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_LOGD;
      cnt_r   <= '0;
      side_r  <= 1'b0;
      pc_r    <= 1'b0;
      rate_r  <= 16'd58982;
      eta_r   <= 15'd5120;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      side_r  <= side_nxt;
      pc_r    <= pc_nxt;
      rate_r  <= rate_nxt;
      eta_r   <= eta_nxt;
      ov_r    <= ov_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    u_r      <= u_nxt;
    blend_r  <= blend_nxt;
    order_r  <= order_nxt;
    y1_r     <= y1_nxt;
    y2_r     <= y2_nxt;
    d_r      <= d_nxt;
    s_r      <= s_nxt;
    x_r      <= x_nxt;
    lz_r     <= lz_nxt;
    fb_r     <= fb_nxt;
    m_r      <= m_nxt;
    frac_r   <= frac_nxt;
    lg_r     <= lg_nxt;
    lgd_r    <= lgd_nxt;
    lb_r     <= lb_nxt;
    y_r      <= y_nxt;
    ex_r     <= ex_nxt;
    alpha_r  <= alpha_nxt;
    hiside_r <= hiside_nxt;
    mres_r   <= mres_nxt;
    bq_r     <= bq_nxt;
    sat_r    <= sat_nxt;
    bhd_r    <= bhd_nxt;
    clo_r    <= clo_nxt;
    res1_r   <= res1_nxt;
    res2_r   <= res2_nxt;
    out1_r   <= out1_nxt;
    out2_r   <= out2_nxt;
  end

  sbxc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({lgneg[35:0], 8'b0}),
    .den   (e_val),
    .done  (div_done),
    .quot  (div_q)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({out2_r, out1_r});

endmodule

[test/tb_sbx_pkg.sv]
package tb_sbx_pkg;

  // Configuration register indexes.
  localparam logic REG_CROSSOVER_RATE     = 1'b0;
  localparam logic REG_DISTRIBUTION_INDEX = 1'b1;

  typedef struct packed {
    logic              first_var;
    logic [15:0]       pair_draw;
    logic signed [31:0] parent_a;
    logic signed [31:0] parent_b;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic              blend_coin;
    logic [31:0]       spread_draw;
    logic              order_coin;
  } sbx_var_t;

endpackage

[test/sbx_checker.sv]
module sbx_checker
  import tb_sbx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [183:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_Q30    = 64'd1 << 30;
  localparam longint unsigned SPREAD_CAP = 64'd1 << 45;
  localparam longint unsigned HALF_RANGE = 64'd1 << 63;

  typedef struct packed {
    logic [31:0] child_one;
    logic [31:0] child_two;
  } children_t;

  children_t   expected_children [$];
  logic [15:0] rate_q;
  logic [14:0] eta_q;
  logic        crossed_q;

  assign pending = expected_children.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-2 log in Q.30: normalize, then one fraction bit per squaring.
  function automatic longint fixed_log2(longint unsigned x, int fb);
    int p;
    longint unsigned m, frac;
    p = 63;
    frac = 0;
    while (p > 0 && !x[p]) p--;
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (ONE_Q30 << 1)) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return longint'(p - fb) * longint'(ONE_Q30) + longint'(frac);
  endfunction

  function automatic longint unsigned fixed_exp2(longint y);
    longint ip;
    longint unsigned frac, m, root;
    ip = y >>> 30;
    frac = longint'(y) & (ONE_Q30 - 1);
    m = ONE_Q30;
    root = ONE_Q30 << 1;
    for (int k = 1; k <= 30; k++) begin
      root = int_sqrt(root << 30);
      if (frac[30 - k]) m = (m * root) >> 30;
    end
    if (ip >= 0) begin
      if (ip > 32) return '1;
      return m << ip;
    end
    if (ip <= -32) return 0;
    return m >> (-ip);
  endfunction

  function automatic longint unsigned spread_factor(longint gap, longint unsigned d,
                                                    longint unsigned u, longint unsigned e);
    longint unsigned num, t, p, alpha, prod, g;
    longint lb, lg;
    if (gap < 0) gap = 0;
    num = d + 2 * longint'(gap);
    lb = fixed_log2(num, 0) - fixed_log2(d, 0);
    if (lb < 0) lb = 0;
    t = (longint'(lb) * e) >> 8;
    p = fixed_exp2(-longint'(t));
    if (p > ONE_Q30) p = ONE_Q30;
    alpha = (ONE_Q30 << 1) - p;
    prod = u * alpha;
    if (prod <= (64'd1 << 62)) begin
      if (prod == 0) return 0;
      lg = fixed_log2(prod, 62);
      g = (longint'(-lg) * 256) / e;
      return fixed_exp2(-longint'(g));
    end
    lg = fixed_log2(HALF_RANGE - prod, 62);
    g = (longint'(-lg) * 256) / e;
    return fixed_exp2(longint'(g));
  endfunction

  // Child = round half up of (sum +/- betaq*d)/2 with spread in quarter LSBs, then clamp.
  function automatic longint spread_child(longint s, longint unsigned betaq, longint unsigned d,
                                          bit upper, longint lo, longint hi);
    longint unsigned bh, bl, w;
    longint c;
    bh = betaq >> 28;
    bl = betaq & ((64'd1 << 28) - 1);
    if (bh != 0 && bh > SPREAD_CAP / d) w = SPREAD_CAP;
    else w = bh * d + ((bl * d) >> 28);
    if (w > SPREAD_CAP) w = SPREAD_CAP;
    if (upper) c = (4 * s + longint'(w) + 4) >>> 3;
    else c = (4 * s - longint'(w) + 4) >>> 3;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return c;
  endfunction

  function automatic children_t crossover(sbx_var_t v, bit crossed, logic [14:0] eta);
    longint a, b, lo, hi, y1, y2, s, c1, c2;
    longint unsigned d, e;
    children_t r;
    a = longint'(v.parent_a);
    b = longint'(v.parent_b);
    lo = longint'(v.lower_bound);
    hi = longint'(v.upper_bound);
    r.child_one = v.parent_a;
    r.child_two = v.parent_b;
    if (crossed && !v.blend_coin) begin
      r.child_one = v.parent_b;
      r.child_two = v.parent_a;
    end else if (crossed && a != b) begin
      y1 = (a < b) ? a : b;
      y2 = (a < b) ? b : a;
      d = longint'(y2 - y1);
      e = longint'(eta) + 256;
      s = y1 + y2;
      c1 = spread_child(s, spread_factor(y1 - lo, d, v.spread_draw, e), d, 1'b0, lo, hi);
      c2 = spread_child(s, spread_factor(hi - y2, d, v.spread_draw, e), d, 1'b1, lo, hi);
      r.child_one = v.order_coin ? c2[31:0] : c1[31:0];
      r.child_two = v.order_coin ? c1[31:0] : c2[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    sbx_var_t  v;
    children_t want;
    bit        crossed_n;
    if (!rst_n) begin
      rate_q    <= 16'd58982;
      eta_q     <= 15'd5120;
      crossed_q <= 1'b0;
      expected_children.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CROSSOVER_RATE) rate_q <= cfg_wdata;
        else eta_q <= cfg_wdata[14:0];
      end
      if (in_tvalid && in_tready) begin
        v.first_var   = in_tuser;
        v.pair_draw   = in_tdata[15:0];
        v.parent_a    = in_tdata[47:16];
        v.parent_b    = in_tdata[79:48];
        v.lower_bound = in_tdata[111:80];
        v.upper_bound = in_tdata[143:112];
        v.blend_coin  = in_tdata[144];
        v.spread_draw = in_tdata[176:145];
        v.order_coin  = in_tdata[177];
        crossed_n = v.first_var ? (v.pair_draw < rate_q) : crossed_q;
        crossed_q <= crossed_n;
        expected_children.push_back(crossover(v, crossed_n, eta_q));
      end
      if (out_tvalid && out_tready) begin
        if (expected_children.size() == 0) begin
          report("unexpected word", out_tdata[31:0], 32'h0);
        end else begin
          want = expected_children.pop_front();
          if (out_tdata[31:0] !== want.child_one)
            report("child_one", out_tdata[31:0], want.child_one);
          if (out_tdata[63:32] !== want.child_two)
            report("child_two", out_tdata[63:32], want.child_two);
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
module tb_top
  import tb_sbx_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [183:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic [15:0]  cfg_wdata;
  int           errors;
  int           pending;
  bit           quiet;
  bit           hold_req;

  simulated_binary_crossover_core dut (.*);

  sbx_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Ready is sampled between edges so the accepting edge is known without a race.
  task automatic send_word(sbx_var_t v);
    logic rdy;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= v.first_var;
    in_tdata  <= {6'b0, v.order_coin, v.spread_draw, v.blend_coin, v.upper_bound,
                  v.lower_bound, v.parent_b, v.parent_a, v.pair_draw};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic send_fields(bit first, logic [15:0] draw, int a, int b, int lo, int hi,
                             bit blend, logic [31:0] u, bit order);
    sbx_var_t v;
    v = '{first, draw, a, b, lo, hi, blend, u, order};
    send_word(v);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  // One parent pair: a bounds style per pair, random content per variable.
  task automatic send_pair(output int n);
    int          mode, len, span, lo, hi, t;
    sbx_var_t    v;
    mode = $urandom_range(0, 9);
    len  = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      v.first_var   = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
      v.pair_draw   = $urandom;
      v.blend_coin  = $urandom_range(0, 5) != 0;
      v.spread_draw = $urandom;
      v.order_coin  = $urandom;
      span = $urandom_range(1, 1 << 24);
      lo   = int'($urandom) >>> $urandom_range(1, 16);
      hi   = lo + span;
      v.lower_bound = lo;
      v.upper_bound = hi;
      v.parent_a    = lo + int'($urandom_range(0, span));
      v.parent_b    = lo + int'($urandom_range(0, span));
      case (mode)
        0: begin
          v.parent_a    = $urandom;
          v.parent_b    = $urandom;
          v.lower_bound = $urandom;
          v.upper_bound = $urandom;
        end
        1: v.parent_a = lo - int'($urandom_range(0, 1 << 20));
        2: v.parent_b = hi + int'($urandom_range(0, 1 << 20));
        3: v.parent_b = v.parent_a + int'($urandom_range(0, 2)) - 1;
        4: begin
          v.lower_bound = hi;
          v.upper_bound = lo;
        end
        default: ;
      endcase
      send_word(v);
    end
    n = len;
  endtask

  initial begin
    logic [15:0] rates [6] = '{16'd58982, 16'd65535, 16'd0, 16'd32768, 16'd65534, 16'd0};
    logic [15:0] etas  [6] = '{16'd5120, 16'd0, 16'd25600, 16'd25600, 16'd1, 16'd0};
    int sent;
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_CROSSOVER_RATE;
    cfg_wdata  = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First word, no pair started yet: parents pass through, draw ignored.
    send_fields(0, 16'd0, 32'h0001_0000, 32'h0005_0000, 0, 32'h000A_0000, 1, 32'h8000_0000, 0);
    send_fields(1, 16'd0, 32'h0001_0000, 32'h0005_0000, 0, 32'h000A_0000, 1, 32'h8000_0000, 0);
    send_fields(0, 16'hFFFF, 32'h0001_0000, 32'h0005_0000, 0, 32'h000A_0000, 1, 32'h0, 1);
    send_fields(0, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                32'hFFFF_FFFF, 1);
    send_fields(0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                32'h0, 0);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h0003_0000, 0, 32'h000A_0000, 1, 32'h4000_0000, 0);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h0003_0001, 0, 32'h000A_0000, 1, 32'h4000_0000, 1);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h0008_0000, 0, 32'h000A_0000, 0, 32'h4000_0000, 0);
    send_fields(0, 16'd0, -32'sh0002_0000, 32'h0008_0000, 0, 32'h000A_0000, 1, 32'hC000_0000, 1);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h000C_0000, 0, 32'h000A_0000, 1, 32'h2000_0000, 0);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h0008_0000, 32'h000A_0000, 0, 1, 32'h7FFF_FFFF, 1);
    send_fields(0, 16'd0, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1,
                32'hFFFF_FFFF, 0);
    send_fields(1, 16'hFFFF, 32'h0001_0000, 32'h0005_0000, 0, 32'h000A_0000, 1, 32'h8000_0000, 0);
    send_fields(0, 16'd0, 32'h0001_0000, 32'h0005_0000, 0, 32'h000A_0000, 0, 32'h8000_0000, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CROSSOVER_RATE, rates[ph]);
      write_reg(REG_DISTRIBUTION_INDEX, ph == 5 ? 16'($urandom_range(0, 25600)) : etas[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) quiet = 1'b1;
      sent = 0;
      while (sent < 320) begin
        send_pair(n);
        sent += n;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
